// File: hdl/lanczos_resample_line_pass_top_defines.svh
// -----------------------------------------------------------------------------
// lanczos_resample_line_pass_top_defines.svh
// Assertion macros used by the line-pass resampler checker.
// -----------------------------------------------------------------------------
`ifndef LANCZOS_RESAMPLE_LINE_PASS_TOP_DEFINES_SVH
`define LANCZOS_RESAMPLE_LINE_PASS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LRLP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lrlp: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LRLP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lrlp: next-cycle check failed");

`endif

// File: hdl/lrlp_pkg.sv
// -----------------------------------------------------------------------------
// lrlp_pkg
// Shared types and constants of the line-pass resampler.
// -----------------------------------------------------------------------------
package lrlp_pkg;

	// Field widths
	localparam int FUNC_W    = 2;
	localparam int INDEX_W   = 11;
	localparam int TAP_IDX_W = 4;
	localparam int WEIGHT_W  = 22;
	localparam int COUNT_W   = 5;
	localparam int SAMPLE_W  = 8;
	localparam int PIXEL_W   = 8;
	localparam int CFG_IDX_W = 1;
	localparam int WIN_W     = INDEX_W + COUNT_W;

	// Datapath widths
	localparam int ACC_W     = 40;
	localparam int PROD_W    = SAMPLE_W + 1 + WEIGHT_W;
	localparam int RED_W     = 14;
	localparam int MAG_W     = 28;
	localparam int RECIP_W   = 29;
	localparam int QPROD_W   = MAG_W + RECIP_W;

	// Division by one million: multiply by ceil(2^48 / 1e6), take bits from 48 up.
	// Exact for magnitudes below 2^28; larger ones saturate anyway.
	localparam int                 RECIP_SHIFT = 48;
	localparam logic [RECIP_W-1:0] RECIP       = 29'd281474977;
	localparam logic [ACC_W-1:0]   SAT_LIMIT   = 40'd256000000;

	// Register reset values
	localparam logic [PIXEL_W-1:0] MIN_LEVEL_RST = 8'd0;
	localparam logic [PIXEL_W-1:0] MAX_LEVEL_RST = 8'd255;

	// Function codes
	localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_SAMPLE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_BASE,
		ST_WR_W,
		ST_WR_S,
		ST_WIN_WAIT,
		ST_MAC,
		ST_DRAIN,
		ST_DIV1,
		ST_DIV2,
		ST_FINISH
	} lrlp_state_t;

	typedef struct packed {
		logic accept;
		logic red_step;
		logic base_load;
		logic wr_weight;
		logic wr_sample;
		logic win_latch;
		logic mac_issue;
		logic div1;
		logic div2;
		logic out_load;
	} lrlp_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              taps_zero;
		logic              last_tap;
		logic              pipe_busy;
		logic              out_free;
	} lrlp_status_t;

endpackage

// File: hdl/lrlp_ram.sv
// -----------------------------------------------------------------------------
// lrlp_ram
// Generic one-write, one-read RAM with registered read data.
// -----------------------------------------------------------------------------
module lrlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/lrlp_ctrl.sv
// -----------------------------------------------------------------------------
// lrlp_ctrl
// Sequencer: accepts one request, steps the datapath through it.
// -----------------------------------------------------------------------------
module lrlp_ctrl #(
	parameter int RED_STEPS = 1,
	parameter int RED_KW    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  lrlp_pkg::lrlp_status_t status,
	output lrlp_pkg::lrlp_cmd_t    cmd,
	output logic [RED_KW-1:0]      red_k
);

	lrlp_pkg::lrlp_state_t state_q, state_d;
	logic [RED_KW-1:0]     red_k_q;

	// State and reduction step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lrlp_pkg::ST_IDLE;
			red_k_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				red_k_q <= RED_KW'(RED_STEPS - 1);
			end else if (cmd.red_step && red_k_q != '0) begin
				red_k_q <= red_k_q - 1'b1;
			end
		end
	end

	assign red_k = red_k_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrlp_pkg::ST_IDLE: begin
				if (in_valid) state_d = lrlp_pkg::ST_REDUCE;
			end
			lrlp_pkg::ST_REDUCE: begin
				if (red_k_q == '0) state_d = lrlp_pkg::ST_BASE;
			end
			lrlp_pkg::ST_BASE: begin
				unique case (status.func)
					lrlp_pkg::FUNC_LOAD_WEIGHT: state_d = lrlp_pkg::ST_WR_W;
					lrlp_pkg::FUNC_LOAD_SAMPLE: state_d = lrlp_pkg::ST_WR_S;
					lrlp_pkg::FUNC_COMPUTE:     state_d = lrlp_pkg::ST_WIN_WAIT;
					default:                    state_d = lrlp_pkg::ST_IDLE;
				endcase
			end
			lrlp_pkg::ST_WR_W:     state_d = lrlp_pkg::ST_IDLE;
			lrlp_pkg::ST_WR_S:     state_d = lrlp_pkg::ST_IDLE;
			lrlp_pkg::ST_WIN_WAIT: state_d = lrlp_pkg::ST_MAC;
			lrlp_pkg::ST_MAC: begin
				if (status.taps_zero || status.last_tap) state_d = lrlp_pkg::ST_DRAIN;
			end
			lrlp_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) state_d = lrlp_pkg::ST_DIV1;
			end
			lrlp_pkg::ST_DIV1:     state_d = lrlp_pkg::ST_DIV2;
			lrlp_pkg::ST_DIV2:     state_d = lrlp_pkg::ST_FINISH;
			lrlp_pkg::ST_FINISH: begin
				if (status.out_free) state_d = lrlp_pkg::ST_IDLE;
			end
			default: state_d = lrlp_pkg::ST_IDLE;
		endcase
	end

	// Commands and input stall
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			lrlp_pkg::ST_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			lrlp_pkg::ST_REDUCE:   cmd.red_step  = 1'b1;
			lrlp_pkg::ST_BASE:     cmd.base_load = 1'b1;
			lrlp_pkg::ST_WR_W:     cmd.wr_weight = 1'b1;
			lrlp_pkg::ST_WR_S:     cmd.wr_sample = 1'b1;
			lrlp_pkg::ST_WIN_WAIT: cmd.win_latch = 1'b1;
			lrlp_pkg::ST_MAC:      cmd.mac_issue = !status.taps_zero;
			lrlp_pkg::ST_DRAIN:    cmd           = '0;
			lrlp_pkg::ST_DIV1:     cmd.div1      = 1'b1;
			lrlp_pkg::ST_DIV2:     cmd.div2      = 1'b1;
			lrlp_pkg::ST_FINISH:   cmd.out_load  = status.out_free;
			default:               cmd           = '0;
		endcase
	end

endmodule

// File: hdl/lrlp_dp.sv
// -----------------------------------------------------------------------------
// lrlp_dp
// Datapath: request registers, slot reduction, weight/window/line memories,
// multiply-accumulate pipeline, divide-and-clamp and output register.
// -----------------------------------------------------------------------------
module lrlp_dp #(
	parameter int LINE_MAX = 2048,
	parameter int OUT_MAX  = 2048,
	parameter int TAPS_MAX = 16,
	parameter int RED_KW   = 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  lrlp_pkg::lrlp_cmd_t                    cmd,
	input  logic [RED_KW-1:0]                      red_k,
	output lrlp_pkg::lrlp_status_t                 status,
	input  logic [lrlp_pkg::FUNC_W-1:0]            func,
	input  logic [lrlp_pkg::INDEX_W-1:0]           out_index,
	input  logic [lrlp_pkg::TAP_IDX_W-1:0]         tap_index,
	input  logic signed [lrlp_pkg::WEIGHT_W-1:0]   tap_weight,
	input  logic [lrlp_pkg::INDEX_W-1:0]           first_source,
	input  logic [lrlp_pkg::COUNT_W-1:0]           tap_count,
	input  logic [lrlp_pkg::INDEX_W-1:0]           sample_index,
	input  logic [lrlp_pkg::SAMPLE_W-1:0]          sample_value,
	input  logic                                   cfg_we,
	input  logic [lrlp_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [lrlp_pkg::PIXEL_W-1:0]           cfg_data,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic [lrlp_pkg::PIXEL_W-1:0]           pixel_out,
	output logic [lrlp_pkg::INDEX_W-1:0]           pixel_index
);

	localparam int LINE_AW  = $clog2(LINE_MAX);
	localparam int OUT_AW   = $clog2(OUT_MAX);
	localparam int WS_DEPTH = OUT_MAX * TAPS_MAX;
	localparam int WS_AW    = $clog2(WS_DEPTH);
	localparam int CNT_W    = $clog2(TAPS_MAX + 1);
	localparam int LSUM_W   = lrlp_pkg::INDEX_W + 1;

	// Request registers
	logic [lrlp_pkg::FUNC_W-1:0]    func_q;
	logic [lrlp_pkg::INDEX_W-1:0]   out_index_q;
	logic [lrlp_pkg::TAP_IDX_W-1:0] tap_index_q;
	logic [lrlp_pkg::WEIGHT_W-1:0]  tap_weight_q;
	logic [lrlp_pkg::INDEX_W-1:0]   first_source_q;
	logic [lrlp_pkg::COUNT_W-1:0]   tap_count_q;
	logic [lrlp_pkg::INDEX_W-1:0]   sample_index_q;
	logic [lrlp_pkg::SAMPLE_W-1:0]  sample_value_q;

	// Slot and window
	logic [lrlp_pkg::RED_W-1:0]     slot_red_q;
	logic [lrlp_pkg::RED_W-1:0]     red_sub;
	logic [OUT_AW-1:0]              slot;
	logic [WS_AW-1:0]               base_q;
	logic [lrlp_pkg::INDEX_W-1:0]   start_q;
	logic [CNT_W-1:0]               taps_q;
	logic [CNT_W-1:0]               tap_q;
	logic [CNT_W-1:0]               taps_sat;

	// Memory ports
	logic [lrlp_pkg::WIN_W-1:0]     win_rdata;
	logic [lrlp_pkg::COUNT_W-1:0]   win_taps;
	logic [lrlp_pkg::WEIGHT_W-1:0]  w_rdata;
	logic [lrlp_pkg::SAMPLE_W-1:0]  line_rdata;
	logic                           w_we;
	logic [WS_AW-1:0]               w_waddr;
	logic [WS_AW-1:0]               w_raddr;
	logic                           line_we;
	logic [LSUM_W-1:0]              line_sum;
	logic [LINE_AW-1:0]             line_raddr;

	// MAC pipeline
	logic                              valid_s1;
	logic                              valid_s2;
	logic signed [lrlp_pkg::PROD_W-1:0] prod_s2;
	logic signed [lrlp_pkg::ACC_W-1:0]  acc_q;

	// Divide and clamp
	logic [lrlp_pkg::ACC_W-1:0]     acc_mag;
	logic [lrlp_pkg::MAG_W-1:0]     mag_s1;
	logic                           neg_s1;
	logic                           big_s1;
	logic [lrlp_pkg::QPROD_W-1:0]   qprod_s2;
	logic                           neg_s2;
	logic                           big_s2;
	logic [lrlp_pkg::PIXEL_W-1:0]   quot;
	logic [lrlp_pkg::PIXEL_W-1:0]   clamped;

	// Configuration and output
	logic [lrlp_pkg::PIXEL_W-1:0]   min_level_q;
	logic [lrlp_pkg::PIXEL_W-1:0]   max_level_q;
	logic                           out_valid_q;
	logic [lrlp_pkg::PIXEL_W-1:0]   pixel_q;
	logic [lrlp_pkg::INDEX_W-1:0]   pixel_index_q;

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q         <= func;
			out_index_q    <= out_index;
			tap_index_q    <= tap_index;
			tap_weight_q   <= tap_weight;
			first_source_q <= first_source;
			tap_count_q    <= tap_count;
			sample_index_q <= sample_index;
			sample_value_q <= sample_value;
		end
	end

	// Reduce the output index modulo OUT_MAX, one shifted subtract a step
	assign red_sub = lrlp_pkg::RED_W'(OUT_MAX) << red_k;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			slot_red_q <= lrlp_pkg::RED_W'(out_index);
		end else if (cmd.red_step && slot_red_q >= red_sub) begin
			slot_red_q <= slot_red_q - red_sub;
		end
	end

	assign slot = slot_red_q[OUT_AW-1:0];

	// Base address of the slot's weight row
	always_ff @(posedge clk) begin
		if (cmd.base_load) begin
			base_q <= WS_AW'(slot * TAPS_MAX);
		end
	end

	// Window store: first source and tap count per slot
	lrlp_ram #(
		.WIDTH (lrlp_pkg::WIN_W),
		.DEPTH (OUT_MAX)
	) u_win_ram (
		.clk   (clk),
		.we    (cmd.wr_weight),
		.waddr (slot),
		.wdata ({first_source_q, tap_count_q}),
		.raddr (slot),
		.rdata (win_rdata)
	);

	// Weight store; out-of-range tap positions drop the weight write
	assign w_we    = cmd.wr_weight && (int'(tap_index_q) < TAPS_MAX);
	assign w_waddr = base_q + WS_AW'(tap_index_q);
	assign w_raddr = base_q + WS_AW'(tap_q);

	lrlp_ram #(
		.WIDTH (lrlp_pkg::WEIGHT_W),
		.DEPTH (WS_DEPTH)
	) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (tap_weight_q),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// Line buffer; reads past the end clamp to the last entry
	assign line_we    = cmd.wr_sample && (int'(sample_index_q) < LINE_MAX);
	assign line_sum   = LSUM_W'(start_q) + LSUM_W'(tap_q);
	assign line_raddr = (int'(line_sum) >= LINE_MAX) ? LINE_AW'(LINE_MAX - 1)
	                                                 : LINE_AW'(line_sum);

	lrlp_ram #(
		.WIDTH (lrlp_pkg::SAMPLE_W),
		.DEPTH (LINE_MAX)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (LINE_AW'(sample_index_q)),
		.wdata (sample_value_q),
		.raddr (line_raddr),
		.rdata (line_rdata)
	);

	// Latch the window, saturating the tap count
	assign win_taps = win_rdata[lrlp_pkg::COUNT_W-1:0];
	assign taps_sat = (int'(win_taps) > TAPS_MAX) ? CNT_W'(TAPS_MAX) : CNT_W'(win_taps);

	always_ff @(posedge clk) begin
		if (cmd.win_latch) begin
			start_q <= win_rdata[lrlp_pkg::WIN_W-1 -: lrlp_pkg::INDEX_W];
			taps_q  <= taps_sat;
		end
	end

	// Tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (cmd.win_latch) begin
			tap_q <= '0;
		end else if (cmd.mac_issue) begin
			tap_q <= CNT_W'(tap_q + 1'b1);
		end
	end

	// MAC pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.mac_issue;
			valid_s2 <= valid_s1;
		end
	end

	// Multiply, then accumulate
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= $signed({1'b0, line_rdata}) * $signed(w_rdata);
		end
		if (cmd.win_latch) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + lrlp_pkg::ACC_W'(prod_s2);
		end
	end

	// Divide by one million toward zero: sign and magnitude, then reciprocal
	assign acc_mag = acc_q[lrlp_pkg::ACC_W-1] ? lrlp_pkg::ACC_W'(-acc_q)
	                                          : lrlp_pkg::ACC_W'(acc_q);

	always_ff @(posedge clk) begin
		if (cmd.div1) begin
			mag_s1 <= acc_mag[lrlp_pkg::MAG_W-1:0];
			neg_s1 <= acc_q[lrlp_pkg::ACC_W-1];
			big_s1 <= acc_mag >= lrlp_pkg::SAT_LIMIT;
		end
		if (cmd.div2) begin
			qprod_s2 <= lrlp_pkg::QPROD_W'(mag_s1) * lrlp_pkg::QPROD_W'(lrlp_pkg::RECIP);
			neg_s2   <= neg_s1;
			big_s2   <= big_s1;
		end
	end

	assign quot = qprod_s2[lrlp_pkg::RECIP_SHIFT +: lrlp_pkg::PIXEL_W];

	// Clamp: test against min first, then max
	always_comb begin
		if (neg_s2 && (big_s2 || quot != '0)) begin
			clamped = min_level_q;
		end else if (big_s2) begin
			clamped = max_level_q;
		end else if (quot < min_level_q) begin
			clamped = min_level_q;
		end else if (quot >= max_level_q) begin
			clamped = max_level_q;
		end else begin
			clamped = quot;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= lrlp_pkg::MIN_LEVEL_RST;
			max_level_q <= lrlp_pkg::MAX_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lrlp_pkg::CFG_MIN_LEVEL: min_level_q <= cfg_data;
				lrlp_pkg::CFG_MAX_LEVEL: max_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_q       <= clamped;
			pixel_index_q <= out_index_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_q;
	assign pixel_index = pixel_index_q;

	// Status to the sequencer
	assign status.func      = func_q;
	assign status.taps_zero = (taps_q == '0);
	assign status.last_tap  = (({1'b0, tap_q} + 1'b1) == {1'b0, taps_q});
	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_free  = !out_valid_q || !out_stall;

endmodule

// File: hdl/lanczos_resample_line_pass_top.sv
// Compute request: the index is reduced, the weight row base loaded and the window latched;
// the taps then go through the MAC, one tap per cycle, and after the pipeline drains the sum
// is divided, clamped and loaded into the output register once it is free. Only then is the
// next request taken. Load requests reduce the index, load the base and write their entry.
// Reset (arst_n low, asynchronous) idles the sequencer, empties the output register and
// sets min_level 0, max_level 255; memory contents are left undefined.
// -----------------------------------------------------------------------------
// lanczos_resample_line_pass_top
// One separable resampling pass: weight sets and a line buffer in RAM, a
// sequenced multiply-accumulate over the taps, scale, clamp and emit a pixel.
// -----------------------------------------------------------------------------
module lanczos_resample_line_pass_top #(
	parameter int LINE_MAX = 2048,
	parameter int OUT_MAX  = 2048,
	parameter int TAPS_MAX = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [lrlp_pkg::FUNC_W-1:0]          func,
	input  logic [lrlp_pkg::INDEX_W-1:0]         out_index,
	input  logic [lrlp_pkg::TAP_IDX_W-1:0]       tap_index,
	input  logic signed [lrlp_pkg::WEIGHT_W-1:0] tap_weight,
	input  logic [lrlp_pkg::INDEX_W-1:0]         first_source,
	input  logic [lrlp_pkg::COUNT_W-1:0]         tap_count,
	input  logic [lrlp_pkg::INDEX_W-1:0]         sample_index,
	input  logic [lrlp_pkg::SAMPLE_W-1:0]        sample_value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [lrlp_pkg::PIXEL_W-1:0]         pixel_out,
	output logic [lrlp_pkg::INDEX_W-1:0]         pixel_index,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lrlp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lrlp_pkg::PIXEL_W-1:0]         cfg_data
);

	localparam int IDX_SPAN  = 2 ** lrlp_pkg::INDEX_W;
	localparam int RED_STEPS = (OUT_MAX >= IDX_SPAN) ? 1 : $clog2(IDX_SPAN / OUT_MAX) + 1;
	localparam int RED_KW    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;

	lrlp_pkg::lrlp_cmd_t    cmd;
	lrlp_pkg::lrlp_status_t status;
	logic [RED_KW-1:0]      red_k;

	// Registers are always writable
	assign cfg_ready = 1'b1;

	lrlp_ctrl #(
		.RED_STEPS (RED_STEPS),
		.RED_KW    (RED_KW)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd),
		.red_k    (red_k)
	);

	lrlp_dp #(
		.LINE_MAX (LINE_MAX),
		.OUT_MAX  (OUT_MAX),
		.TAPS_MAX (TAPS_MAX),
		.RED_KW   (RED_KW)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.red_k        (red_k),
		.status       (status),
		.func         (func),
		.out_index    (out_index),
		.tap_index    (tap_index),
		.tap_weight   (tap_weight),
		.first_source (first_source),
		.tap_count    (tap_count),
		.sample_index (sample_index),
		.sample_value (sample_value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pixel_out    (pixel_out),
		.pixel_index  (pixel_index)
	);

endmodule

// File: hdl/lrlp_checker.sv
// -----------------------------------------------------------------------------
// lrlp_checker
// Port-level checks of the line-pass resampler, bound to the top level.
// -----------------------------------------------------------------------------
`include "lanczos_resample_line_pass_top_defines.svh"

module lrlp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [lrlp_pkg::PIXEL_W-1:0]  pixel_out,
	input logic [lrlp_pkg::INDEX_W-1:0]  pixel_index
);

	// A stalled result stays offered
	`LRLP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)

	// A stalled result keeps its payload
	`LRLP_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(pixel_out) && $stable(pixel_index))

	// An accepted request always occupies the sequencer for the next cycle
	`LRLP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// A new result only appears out of a request in progress
	`LRLP_ASSERT_IMPLY(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind lanczos_resample_line_pass_top lrlp_checker u_lrlp_checker (.*);
